// ===== hdl/sst_pkg.sv =====
// Shared constants, types and helper functions for the slot set table.
// Used by sst_occ and slot_set_table_top; depends on nothing else.
package sst_pkg;

    // Table geometry
    localparam int SLOTS     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);

    // Operation codes carried by the mode field
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIRST  = 2'd2,
        MODE_NEXT   = 2'd3
    } mode_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_PROBE,
        ST_MATCH
    } state_t;

    // Update request to the occupancy map
    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } occ_cmd_t;

    // Summary of the occupancy map
    typedef struct packed {
        logic [SLOTS-1:0] valid;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] free_idx;
        logic             full;
    } occ_stat_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [IDX_W-1:0] lowest_idx(input logic [SLOTS-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/sst_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sst_occ.sv =====
// Occupancy map of the slot set table: one valid bit per slot plus the occupancy count.
// Depends on sst_pkg for geometry, the update command and the status struct.
module sst_occ (
    input  logic              clk,
    input  logic              rst_n,
    input  sst_pkg::occ_cmd_t cmd,
    output sst_pkg::occ_stat_t stat
);

    logic [sst_pkg::SLOTS-1:0] valid_reg;
    logic [sst_pkg::SLOTS-1:0] valid_next;
    logic [sst_pkg::CNT_W-1:0] count_reg;
    logic [sst_pkg::CNT_W-1:0] count_next;
    logic [sst_pkg::SLOTS-1:0] one_hot;

    // Apply a set or clear of one slot and keep the count in step.
    always_comb
    begin
        one_hot    = {{(sst_pkg::SLOTS-1){1'b0}}, 1'b1} << cmd.idx;
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.set)
        begin
            valid_next = valid_reg | one_hot;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.clr)
        begin
            valid_next = valid_reg & ~one_hot;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // The lowest free slot always exists while the table is not full.
    assign stat.valid    = valid_reg;
    assign stat.count    = count_reg;
    assign stat.free_idx = sst_pkg::lowest_idx(~valid_reg);
    assign stat.full     = (count_reg == sst_pkg::CNT_W'(sst_pkg::SLOTS));

endmodule

// ===== hdl/slot_set_table_top.sv =====
// Slot set table: handle slots held in a RAM, with occupancy bits and a first/next cursor.
// Depends on sst_pkg, sst_ram and sst_occ.
//
// A word is accepted when start is high and busy is low; its result appears on the
// result ports for exactly one cycle with done high, and cannot be held off. An add,
// any add or remove of the null key, and a first or next that finds nothing end in
// the decode state. A first or next that finds an entry goes on to the fetch state,
// because the entry is read from the slot RAM, whose read data is registered. A remove
// examines the occupied slots in ascending order through the single RAM read port,
// a probe state and then a match state per slot, and ends at the first match or when
// no candidate is left (at most 16 slots are examined). Busy falls in the cycle that
// done is high, so the next word can be accepted while a result is shown. The slot
// contents need no clearing after reset: a slot counts only while its valid bit is set.
module slot_set_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic [sst_pkg::KEY_WIDTH-1:0] key,
    output logic                          done,
    output logic [sst_pkg::KEY_WIDTH-1:0] entry_out,
    output logic                          found,
    output logic                          status,
    output logic [sst_pkg::CNT_W-1:0]     occupancy,
    output logic                          non_empty
);

    sst_pkg::state_t state_reg;
    sst_pkg::state_t state_next;
    sst_pkg::mode_t  mode_reg;

    logic [sst_pkg::KEY_WIDTH-1:0] key_reg;
    logic [sst_pkg::IDX_W-1:0]     iter_reg;
    logic [sst_pkg::IDX_W-1:0]     iter_next;
    logic [sst_pkg::SLOTS-1:0]     cand_reg;
    logic [sst_pkg::SLOTS-1:0]     cand_next;
    logic [sst_pkg::IDX_W-1:0]     idx_reg;
    logic [sst_pkg::IDX_W-1:0]     idx_next;

    logic                          done_reg;
    logic                          done_next;
    logic [sst_pkg::KEY_WIDTH-1:0] entry_reg;
    logic [sst_pkg::KEY_WIDTH-1:0] entry_next;
    logic                          found_reg;
    logic                          found_next;
    logic                          status_reg;
    logic                          status_next;

    logic                          accept;
    logic                          key_zero;
    logic [sst_pkg::SLOTS-1:0]     above;
    logic [sst_pkg::SLOTS-1:0]     hits;
    logic                          hits_any;
    logic                          cand_any;
    logic [sst_pkg::IDX_W-1:0]     probe_idx;
    logic                          match;

    logic                          ram_we;
    logic                          ram_re;
    logic [sst_pkg::IDX_W-1:0]     ram_raddr;
    logic [sst_pkg::KEY_WIDTH-1:0] ram_rdata;

    sst_pkg::occ_cmd_t  occ_cmd;
    sst_pkg::occ_stat_t occ_stat;

    assign busy   = (state_reg != sst_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Slot contents
    sst_ram #(
        .WIDTH (sst_pkg::KEY_WIDTH),
        .DEPTH (sst_pkg::SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (occ_stat.free_idx),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Valid bits and occupancy count
    sst_occ u_occ (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (occ_cmd),
        .stat  (occ_stat)
    );

    // Search conditions: occupied slots above the cursor for next, all of them for first.
    always_comb
    begin
        for (int i = 0; i < sst_pkg::SLOTS; i++) begin
            above[i] = (sst_pkg::IDX_W'(i) > iter_reg);
        end
        hits      = (mode_reg == sst_pkg::MODE_NEXT) ? (occ_stat.valid & above) : occ_stat.valid;
        hits_any  = |hits;
        cand_any  = |cand_reg;
        probe_idx = sst_pkg::lowest_idx(cand_reg);
        key_zero  = (key_reg == '0);
        match     = (ram_rdata == key_reg);
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sst_pkg::ST_DECODE;
                end
            end
            sst_pkg::ST_DECODE:
            begin
                unique case (mode_reg)
                    sst_pkg::MODE_ADD:
                    begin
                        state_next = sst_pkg::ST_IDLE;
                    end
                    sst_pkg::MODE_REMOVE:
                    begin
                        state_next = key_zero ? sst_pkg::ST_IDLE : sst_pkg::ST_PROBE;
                    end
                    sst_pkg::MODE_FIRST, sst_pkg::MODE_NEXT:
                    begin
                        state_next = hits_any ? sst_pkg::ST_FETCH : sst_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = sst_pkg::ST_IDLE;
                    end
                endcase
            end
            sst_pkg::ST_FETCH:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
            sst_pkg::ST_PROBE:
            begin
                state_next = cand_any ? sst_pkg::ST_MATCH : sst_pkg::ST_IDLE;
            end
            sst_pkg::ST_MATCH:
            begin
                state_next = match ? sst_pkg::ST_IDLE : sst_pkg::ST_PROBE;
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath control
    always_comb
    begin
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = probe_idx;
        occ_cmd     = '0;
        iter_next   = iter_reg;
        cand_next   = cand_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        entry_next  = '0;
        found_next  = 1'b0;
        status_next = 1'b0;
        unique case (state_reg)
            sst_pkg::ST_IDLE:
            begin
            end
            sst_pkg::ST_DECODE:
            begin
                unique case (mode_reg)
                    sst_pkg::MODE_ADD:
                    begin
                        // Store into the lowest free slot unless null or full.
                        done_next = 1'b1;
                        if (!key_zero)
                        begin
                            if (occ_stat.full)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                occ_cmd.set = 1'b1;
                                occ_cmd.idx = occ_stat.free_idx;
                                found_next  = 1'b1;
                            end
                        end
                    end
                    sst_pkg::MODE_REMOVE:
                    begin
                        // Only occupied slots are candidates for a match.
                        if (key_zero)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cand_next = occ_stat.valid;
                        end
                    end
                    sst_pkg::MODE_FIRST, sst_pkg::MODE_NEXT:
                    begin
                        if (hits_any)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = sst_pkg::lowest_idx(hits);
                            iter_next = sst_pkg::lowest_idx(hits);
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            sst_pkg::ST_FETCH:
            begin
                done_next  = 1'b1;
                entry_next = ram_rdata;
                found_next = 1'b1;
            end
            sst_pkg::ST_PROBE:
            begin
                // Read the lowest remaining candidate, or report no match.
                if (cand_any)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = probe_idx;
                    idx_next  = probe_idx;
                    cand_next = cand_reg & ~({{(sst_pkg::SLOTS-1){1'b0}}, 1'b1} << probe_idx);
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            sst_pkg::ST_MATCH:
            begin
                if (match)
                begin
                    occ_cmd.clr = 1'b1;
                    occ_cmd.idx = idx_reg;
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= sst_pkg::mode_t'(mode);
            key_reg  <= key;
        end
        cand_reg   <= cand_next;
        idx_reg    <= idx_next;
        entry_reg  <= entry_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // The count already holds its new value in the cycle the result word is shown.
    assign done      = done_reg;
    assign entry_out = entry_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign occupancy = occ_stat.count;
    assign non_empty = |occ_stat.count;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != sst_pkg::ST_IDLE)
        else $error("result word without an item in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_stat.valid) == int'(occ_stat.count))
        else $error("occupancy count out of step with valid bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> (occ_stat.full && !found_reg))
        else $error("add rejected while the table has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sst_pkg::ST_MATCH) |-> $past(ram_re))
        else $error("compare without a slot read in the previous cycle");

endmodule

// ===== test/slot_set_table_top_tb.sv =====
// Self-checking testbench for slot_set_table_top: directed and random add, remove,
// first and next words, each result checked against a behavioural model of the table.
// Depends on sst_pkg and the RTL of slot_set_table_top.
module slot_set_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 48;
    localparam int RANDOM_WORDS = 600;

    // Flavours of random phase; each leans the operation mix a different way.
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_ITERATE,
        PH_MIXED
    } phase_t;

    // One expected result word.
    typedef struct packed {
        logic [KEY_WIDTH-1:0] entry;
        logic                 found;
        logic                 status;
        logic [CNT_W-1:0]     occupancy;
        logic                 non_empty;
    } table_result_t;

    // Scoreboard: keeps its own copy of the table and a queue of expected results.
    class SlotTableScoreboard;
        logic [KEY_WIDTH-1:0] slot_key [SLOTS];
        int                   held;
        int                   cursor;
        table_result_t        pending_results [$];
        int                   failures;

        function new();
            foreach (slot_key[i])
            begin
                slot_key[i] = '0;
            end
            held     = 0;
            cursor   = 0;
            failures = 0;
        endfunction

        // Lowest occupied slot at or above from; -1 when there is none.
        function int lowest_from(int from);
            for (int i = from; i < SLOTS; i++)
            begin
                if (slot_key[i] != '0)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply an accepted word to the model and queue the result it gives.
        function void note_word(mode_t op, logic [KEY_WIDTH-1:0] k);
            table_result_t r;
            int            pos;
            r = '0;
            case (op)
                MODE_ADD:
                begin
                    if (k != '0)
                    begin
                        if (held >= SLOTS)
                        begin
                            r.status = 1'b1;
                        end
                        else
                        begin
                            pos = -1;
                            for (int i = 0; i < SLOTS && pos < 0; i++)
                            begin
                                if (slot_key[i] == '0)
                                begin
                                    pos = i;
                                end
                            end
                            if (pos >= 0)
                            begin
                                slot_key[pos] = k;
                                held++;
                                r.found = 1'b1;
                            end
                            else
                            begin
                                r.status = 1'b1;
                            end
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (k != '0)
                    begin
                        pos = -1;
                        for (int i = 0; i < SLOTS && pos < 0; i++)
                        begin
                            if (slot_key[i] == k)
                            begin
                                pos = i;
                            end
                        end
                        if (pos >= 0)
                        begin
                            slot_key[pos] = '0;
                            if (held > 0)
                            begin
                                held--;
                            end
                            r.found = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // First searches from slot 0, next from just above the cursor.
                    pos = lowest_from(op == MODE_FIRST ? 0 : cursor + 1);
                    if (pos >= 0)
                    begin
                        cursor  = pos;
                        r.entry = slot_key[pos];
                        r.found = 1'b1;
                    end
                end
            endcase
            r.occupancy = CNT_W'(held);
            r.non_empty = (held > 0);
            pending_results.push_back(r);
        endfunction

        // Compare one result word with the oldest expectation.
        function void check_result(logic [KEY_WIDTH-1:0] entry, logic f, logic s,
                                   logic [CNT_W-1:0] occ, logic ne);
            table_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                failures++;
                return;
            end
            e = pending_results.pop_front();
            if (entry !== e.entry)
            begin
                $error("entry_out: expected %h, actual %h", e.entry, entry);
                failures++;
            end
            if (f !== e.found)
            begin
                $error("found: expected %0d, actual %0d", e.found, f);
                failures++;
            end
            if (s !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, s);
                failures++;
            end
            if (occ !== e.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", e.occupancy, occ);
                failures++;
            end
            if (ne !== e.non_empty)
            begin
                $error("non_empty: expected %0d, actual %0d", e.non_empty, ne);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // A key currently held in the table, or a random one if the table is empty.
        function logic [KEY_WIDTH-1:0] held_key();
            int occupied [$];
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_key[i] != '0)
                begin
                    occupied.push_back(i);
                end
            end
            if (occupied.size() == 0)
            begin
                return KEY_WIDTH'($urandom);
            end
            return slot_key[occupied[$urandom_range(0, occupied.size() - 1)]];
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           mode;
    logic [KEY_WIDTH-1:0] key;
    logic                 done;
    logic [KEY_WIDTH-1:0] entry_out;
    logic                 found;
    logic                 status;
    logic [CNT_W-1:0]     occupancy;
    logic                 non_empty;

    SlotTableScoreboard sb = new();

    slot_set_table_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .key       (key),
        .done      (done),
        .entry_out (entry_out),
        .found     (found),
        .status    (status),
        .occupancy (occupancy),
        .non_empty (non_empty)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Result monitor: every strobed word is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(entry_out, found, status, occupancy, non_empty);
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // Present one word after a gap of idle cycles and wait until it is taken.
    task automatic send_word(input mode_t op, input logic [KEY_WIDTH-1:0] k, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        mode  <= op;
        key   <= k;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_word(op, k);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic wait_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Gap before a word: mostly none or short, now and then long.
    function automatic int pick_gap(bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Key choice: held keys so removes hit, a small pool for duplicates, some null.
    function automatic logic [KEY_WIDTH-1:0] pick_key(int held_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return '0;
        end
        if (r < 5 + held_pct)
        begin
            return sb.held_key();
        end
        if (r < 5 + held_pct + (95 - held_pct) / 2)
        begin
            return KEY_WIDTH'($urandom_range(1, 8));
        end
        return KEY_WIDTH'($urandom);
    endfunction

    // Operation mix for each flavour of phase.
    function automatic mode_t pick_mode(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                return r < 70 ? MODE_ADD : r < 80 ? MODE_REMOVE : r < 90 ? MODE_FIRST : MODE_NEXT;
            PH_DRAIN:
                return r < 15 ? MODE_ADD : r < 80 ? MODE_REMOVE : r < 88 ? MODE_FIRST : MODE_NEXT;
            PH_ITERATE:
                return r < 10 ? MODE_ADD : r < 20 ? MODE_REMOVE : r < 35 ? MODE_FIRST : MODE_NEXT;
            default:
                return mode_t'($urandom_range(0, 3));
        endcase
    endfunction

    // Main stimulus.
    initial
    begin
        int     sent;
        int     len;
        phase_t ph;
        bit     no_idle;
        mode_t  op;

        start = 1'b0;
        mode  = MODE_ADD;
        key   = '0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed words: empty-table searches, null and absent keys, bit extremes,
        // next without a prior first, duplicates and a first followed by a next.
        send_word(MODE_FIRST,  32'h0000_0000, 1);
        send_word(MODE_NEXT,   32'h0000_0000, 0);
        send_word(MODE_ADD,    32'h0000_0000, 0);
        send_word(MODE_REMOVE, 32'h0000_0000, 0);
        send_word(MODE_REMOVE, 32'h0000_0005, 0);
        send_word(MODE_ADD,    32'hFFFF_FFFF, 0);
        send_word(MODE_ADD,    32'h0000_0001, 0);
        send_word(MODE_NEXT,   32'hFFFF_FFFF, 0);
        send_word(MODE_NEXT,   32'h0000_0000, 2);
        send_word(MODE_ADD,    32'h0000_0001, 0);
        send_word(MODE_REMOVE, 32'h0000_0001, 0);
        send_word(MODE_FIRST,  32'hAAAA_AAAA, 0);
        send_word(MODE_NEXT,   32'h5555_5555, 0);
        send_word(MODE_NEXT,   32'h0000_0000, 0);
        send_word(MODE_ADD,    32'hAAAA_AAAA, 0);
        send_word(MODE_ADD,    32'h5555_5555, 1);
        send_word(MODE_ADD,    32'h8000_0000, 0);
        send_word(MODE_FIRST,  32'h0000_0000, 0);
        send_word(MODE_NEXT,   32'h0000_0000, 0);
        send_word(MODE_REMOVE, 32'hFFFF_FFFF, 0);
        send_word(MODE_REMOVE, 32'h8000_0000, 3);
        wait_until_drained();

        // Fill the table to the brim, then try one add too many.
        while (sb.held < SLOTS)
        begin
            send_word(MODE_ADD, KEY_WIDTH'($urandom_range(1, 255)), 0);
        end
        send_word(MODE_ADD, 32'h1234_5678, 0);

        // Random phases with differing operation mixes and idling.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            ph      = phase_t'($urandom_range(0, 3));
            len     = $urandom_range(15, 45);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < len; n++)
            begin
                op = pick_mode(ph);
                send_word(op, pick_key(op == MODE_REMOVE ? 70 : 25), pick_gap(no_idle));
            end
            sent += len;
            if ($urandom_range(0, 3) == 0)
            begin
                wait_until_drained();
            end
        end

        // Let the last results come out, then a few quiet cycles.
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.outstanding() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
